// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/s1pd_pkg.sv =====
// ---------------------------------------------------------------------------
// s1pd_pkg
// Shared constants of the S1 peak detector.
// ---------------------------------------------------------------------------
package s1pd_pkg;
  localparam int DEF_WINDOW_DEPTH  = 64;
  localparam int DEF_MAX_NEIGHBORS = 31;
  localparam int DEF_SAMPLE_BITS   = 16;

  localparam int K_W        = 5;
  localparam int H_W        = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int CNT_W      = 32;
  localparam int M2_W       = 64;

  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_STDEVS = 2'd1;

  localparam logic [K_W-1:0] K_RESET = 5'd3;
  localparam logic [H_W-1:0] H_RESET = 12'd384;
endpackage

// ===== sv/s1_peak_detector.sv =====
// A warm-up word goes straight to its result; a scored word first reads the
// candidate and scans its neighbours, then updates the statistics, and a word
// that reaches the threshold test also runs the square and threshold products.
// One word at a time; the divider runs twice per scored word, the serial
// multiplier twice per tested word, the RAM read port once per neighbor and candidate.
// Reset clears counters and statistics; window RAM contents stay undefined.
// ---------------------------------------------------------------------------
// s1_peak_detector
// S1 peak scoring over a RAM sample window with Welford running statistics.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module s1_peak_detector #(
  parameter int WINDOW_DEPTH  = s1pd_pkg::DEF_WINDOW_DEPTH,
  parameter int MAX_NEIGHBORS = s1pd_pkg::DEF_MAX_NEIGHBORS,
  parameter int SAMPLE_BITS   = s1pd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // sample channel
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              evaluated,
  output logic                              peak_found,
  output logic signed [SAMPLE_BITS+1:0]     peak_measure,
  output logic [s1pd_pkg::CNT_W-1:0]        peak_position,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [s1pd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [s1pd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int K_W   = s1pd_pkg::K_W;
  localparam int H_W   = s1pd_pkg::H_W;
  localparam int CNT_W = s1pd_pkg::CNT_W;
  localparam int M2_W  = s1pd_pkg::M2_W;

  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int K_HALF = (WINDOW_DEPTH - 1) / 2;
  localparam int K_LIM  = (MAX_NEIGHBORS < K_HALF) ? MAX_NEIGHBORS : K_HALF;
  localparam int BW     = K_W + 1;                 // back offset up to 2k
  localparam int AIW    = ((AW > BW) ? AW : BW) + 2;
  localparam int FILL_MAX = 2 * K_LIM + 2;
  localparam int FW     = $clog2(FILL_MAX + 1);

  localparam int SW    = SAMPLE_BITS;
  localparam int DFW   = SW + 1;                   // candidate minus neighbor
  localparam int SCW   = SW + 2;                   // score
  localparam int XS_W  = SCW + 18;                 // score * 2^18, also mean width
  localparam int D_W   = XS_W + 1;                 // differences against the mean
  localparam int AB_W  = D_W - 9;
  localparam int PRD_W = 2 * AB_W;
  localparam int SUM_W = ((PRD_W > M2_W) ? PRD_W : M2_W) + 1;
  localparam int H2_W  = 2 * H_W + 2;
  localparam int PROD_W = (2 * D_W > H2_W + M2_W) ? 2 * D_W : H2_W + M2_W;
  localparam int MCW   = $clog2(PROD_W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CAND, S_SCAN, S_DRAIN, S_STAT, S_DELTA, S_DIVM_GO, S_DIVM_WAIT,
    S_M2_MUL, S_M2_ADD, S_DIVV_GO, S_DIVV_WAIT, S_SQ, S_RHS, S_CMP, S_FINISH
  } state_t;

  typedef enum logic [1:0] {TAG_NONE, TAG_CAND, TAG_LEFT, TAG_RIGHT} tag_t;

  state_t state;
  tag_t   rd_tag;

  // configuration
  logic [K_W-1:0] neighbor_count;
  logic [H_W-1:0] threshold_stdevs;

  // window bookkeeping
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  newest;
  logic [FW-1:0]  fill;
  logic [K_W-1:0] kc;
  logic [BW-1:0]  jcnt;

  // scoring
  logic signed [SW-1:0]  cand;
  logic signed [DFW-1:0] maxl;
  logic signed [DFW-1:0] maxr;
  logic signed [SCW-1:0] score;

  // statistics
  logic [CNT_W-1:0]       sample_count;
  logic [CNT_W-1:0]       stat_count;
  logic signed [XS_W-1:0] running_mean;
  logic [M2_W-1:0]        running_m2;
  logic [CNT_W-1:0]       last_peak_position;
  logic signed [D_W-1:0]  delta;
  logic signed [D_W-1:0]  dev;
  logic signed [PRD_W-1:0] prod;
  logic [M2_W-1:0]        variance;

  // serial multiplier
  logic [PROD_W-1:0] mul_acc;
  logic [PROD_W-1:0] mul_a;
  logic [63:0]       mul_b;
  logic [MCW-1:0]    mul_cnt;
  logic [PROD_W-1:0] mul_sum;
  logic [PROD_W-1:0] lhs;

  logic cur_eval;
  logic cur_found;

  // RAM
  logic              accept;
  logic [BW-1:0]     rd_back;
  logic [AIW-1:0]    addr_sum;
  logic [AIW-1:0]    addr_mod;
  logic [AW-1:0]     rd_addr;
  logic [SW-1:0]     rd_data;

  // divider
  logic              div_start;
  logic [63:0]       div_dividend;
  logic              div_done;
  logic [63:0]       div_quot;

  // combinational helpers
  logic [K_W-1:0]         kc_in;
  logic [FW-1:0]          fill_inc;
  logic [FW-1:0]          need_fill;
  logic signed [DFW-1:0]  diff;
  logic signed [D_W-1:0]  xs_w;
  logic signed [D_W-1:0]  mean_w;
  logic [D_W-1:0]         delta_mag;
  logic signed [D_W-1:0]  q_s;
  logic signed [D_W-1:0]  mnew_w;
  logic [SUM_W-1:0]       m2_sum;
  logic [H2_W-1:0]        h2;
  logic [BW-1:0]          jcnt_inc;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);
  assign cfg_ready    = 1'b1;

  always_comb begin
    kc_in     = (32'(neighbor_count) > K_LIM) ? K_W'(K_LIM) : neighbor_count;
    fill_inc  = (fill == FW'(FILL_MAX)) ? fill : fill + FW'(1);
    need_fill = FW'(32'(kc_in) * 2 + 2);

    // ring address of the word "rd_back" places before the newest one
    rd_back  = (state == S_CAND) ? BW'(kc) : jcnt;
    addr_sum = AIW'(newest) + AIW'(WINDOW_DEPTH) - AIW'(rd_back);
    addr_mod = (addr_sum >= AIW'(WINDOW_DEPTH)) ? addr_sum - AIW'(WINDOW_DEPTH) : addr_sum;
    rd_addr  = addr_mod[AW-1:0];

    jcnt_inc = jcnt + BW'(1);
    diff     = $signed({cand[SW-1], cand}) - $signed({rd_data[SW-1], rd_data});

    xs_w      = $signed({score[SCW-1], score, 18'b0});
    mean_w    = $signed({running_mean[XS_W-1], running_mean});
    delta_mag = delta[D_W-1] ? D_W'(-delta) : D_W'(delta);
    q_s       = delta[D_W-1] ? -$signed(div_quot[D_W-1:0]) : $signed(div_quot[D_W-1:0]);
    mnew_w    = mean_w + q_s;

    m2_sum = SUM_W'(running_m2) + SUM_W'(prod[PRD_W-2:0]);
    h2     = {2'(0), threshold_stdevs} * {2'(0), threshold_stdevs} * H2_W'(4);

    mul_sum = mul_b[0] ? mul_acc + mul_a : mul_acc;

    div_start    = (state == S_DIVM_GO) || (state == S_DIVV_GO);
    div_dividend = (state == S_DIVM_GO) ? 64'(delta_mag) : running_m2;
  end

  s1pd_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (wptr),
    .wdata (sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  s1pd_div #(
    .DIVIDEND_W (64),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (stat_count),
    .done     (div_done),
    .quotient (div_quot)
  );

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count   <= s1pd_pkg::K_RESET;
      threshold_stdevs <= s1pd_pkg::H_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        s1pd_pkg::REG_NEIGHBOR_COUNT:   neighbor_count   <= cfg_data[K_W-1:0];
        s1pd_pkg::REG_THRESHOLD_STDEVS: threshold_stdevs <= cfg_data[H_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      rd_tag             <= TAG_NONE;
      wptr               <= '0;
      fill               <= '0;
      sample_count       <= '0;
      stat_count         <= '0;
      running_mean       <= '0;
      running_m2         <= '0;
      last_peak_position <= '0;
      result_valid       <= 1'b0;
    end else begin
      // S_FINISH loads the next word itself
      if (result_valid && !result_stall && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end

      // consume the read issued last cycle
      case (rd_tag)
        TAG_CAND:  cand <= rd_data;
        TAG_LEFT:  if (diff > maxl) maxl <= diff;
        TAG_RIGHT: if (diff > maxr) maxr <= diff;
        default: ;
      endcase

      case (state)
        S_IDLE: begin
          if (accept) begin
            newest       <= wptr;
            wptr         <= (wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr + AW'(1);
            sample_count <= sample_count + CNT_W'(1);
            fill         <= fill_inc;
            kc           <= kc_in;
            cur_found    <= 1'b0;
            if (fill_inc >= need_fill) begin
              cur_eval <= 1'b1;
              state    <= S_CAND;
            end else begin
              cur_eval <= 1'b0;
              state    <= S_FINISH;
            end
          end
        end
        S_CAND: begin
          rd_tag <= TAG_CAND;
          maxl   <= '1;
          maxr   <= '1;
          jcnt   <= '0;
          state  <= (kc == '0) ? S_DRAIN : S_SCAN;
        end
        S_SCAN: begin
          rd_tag <= (jcnt > BW'(kc)) ? TAG_LEFT : TAG_RIGHT;
          // skip the candidate itself
          jcnt   <= (jcnt_inc == BW'(kc)) ? jcnt_inc + BW'(1) : jcnt_inc;
          if (jcnt == {kc, 1'b0}) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          rd_tag <= TAG_NONE;
          state  <= S_STAT;
        end
        S_STAT: begin
          score <= SCW'(maxl) + SCW'(maxr);
          if (stat_count != '1) begin
            stat_count <= stat_count + CNT_W'(1);
          end
          state <= S_DELTA;
        end
        S_DELTA: begin
          delta <= xs_w - mean_w;
          state <= S_DIVM_GO;
        end
        S_DIVM_GO: begin
          state <= S_DIVM_WAIT;
        end
        S_DIVM_WAIT: begin
          if (div_done) begin
            running_mean <= mnew_w[XS_W-1:0];
            dev          <= xs_w - mnew_w;
            state        <= S_M2_MUL;
          end
        end
        S_M2_MUL: begin
          // arithmetic shift right by 9 is floor division by 512
          prod  <= $signed(dev[D_W-1:9]) * $signed(delta[D_W-1:9]);
          state <= S_M2_ADD;
        end
        S_M2_ADD: begin
          if (!prod[PRD_W-1] && (prod != '0)) begin
            running_m2 <= (|m2_sum[SUM_W-1:M2_W]) ? '1 : m2_sum[M2_W-1:0];
          end
          state <= S_DIVV_GO;
        end
        S_DIVV_GO: begin
          state <= S_DIVV_WAIT;
        end
        S_DIVV_WAIT: begin
          if (div_done) begin
            variance <= div_quot;
            if ((score > 0) && (dev > 0)) begin
              mul_acc <= '0;
              mul_a   <= PROD_W'(unsigned'(dev));
              mul_b   <= 64'(unsigned'(dev));
              mul_cnt <= MCW'(D_W);
              state   <= S_SQ;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SQ: begin
          if (mul_cnt == MCW'(1)) begin
            lhs     <= mul_sum;
            mul_acc <= '0;
            mul_a   <= PROD_W'(variance);
            mul_b   <= 64'(h2);
            mul_cnt <= MCW'(H2_W);
            state   <= S_RHS;
          end else begin
            mul_acc <= mul_sum;
            mul_a   <= mul_a << 1;
            mul_b   <= mul_b >> 1;
            mul_cnt <= mul_cnt - MCW'(1);
          end
        end
        S_RHS: begin
          mul_acc <= mul_sum;
          mul_a   <= mul_a << 1;
          mul_b   <= mul_b >> 1;
          mul_cnt <= mul_cnt - MCW'(1);
          if (mul_cnt == MCW'(1)) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (lhs > mul_acc) begin
            cur_found          <= 1'b1;
            last_peak_position <= sample_count;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result_valid  <= 1'b1;
            evaluated     <= cur_eval;
            peak_found    <= cur_found;
            peak_measure  <= cur_eval ? score : '0;
            peak_position <= last_peak_position;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, sample_stall)
  `ASSERT_IMPLIES(a_idle_word_clean, clk, rst, result_valid && !evaluated, !peak_found && peak_measure == '0)
  `ASSERT_IMPLIES(a_peak_scored, clk, rst, result_valid && peak_found, evaluated && peak_measure > 0)
  `ASSERT_IMPLIES(a_div_expected, clk, rst, div_done, state == S_DIVM_WAIT || state == S_DIVV_WAIT)
endmodule

// ===== sv/s1pd_ram.sv =====
// ---------------------------------------------------------------------------
// s1pd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module s1pd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/s1pd_div.sv =====
// ---------------------------------------------------------------------------
// s1pd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module s1pd_div #(
  parameter int DIVIDEND_W = 64,
  parameter int DIVISOR_W  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);
  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
        cnt      <= CW'(DIVIDEND_W);
        busy     <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= DIVISOR_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[DIVISOR_W-1:0];
        end
        quotient <= {quotient[DIVIDEND_W-2:0], fits};
        cnt      <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for s1_peak_detector: random and directed samples, the
// config registers swept between phases, results compared against a local
// S1 score and running-statistics predictor.
// ---------------------------------------------------------------------------
class peak_scoreboard;
  typedef struct {
    bit               evaluated;
    bit               peak_found;
    bit signed [17:0] peak_measure;
    bit [31:0]        peak_position;
  } peak_result_t;

  // predictor state
  int unsigned       k_reg;
  int unsigned       h_reg;
  int                ring[64];
  int unsigned       wr_idx;
  bit [31:0]         n_samples;
  bit [31:0]         n_scored;
  longint            mean_q18;
  bit [63:0]         m2_q18;
  bit [31:0]         peak_pos;
  int unsigned       fill;
  peak_result_t      pending[$];
  int                errors;

  function void clear();
    k_reg = 3; h_reg = 384; wr_idx = 0; n_samples = 0; n_scored = 0;
    mean_q18 = 0; m2_q18 = 0; peak_pos = 0; fill = 0; errors = 0;
    foreach (ring[i]) ring[i] = 0;
  endfunction

  function void write_reg(int unsigned idx, int unsigned val);
    if (idx == s1pd_pkg::REG_NEIGHBOR_COUNT) k_reg = val & 31;
    else if (idx == s1pd_pkg::REG_THRESHOLD_STDEVS) h_reg = val & 4095;
  endfunction

  function int back_at(int unsigned back);
    return ring[(wr_idx + 127 - back) % 64];
  endfunction

  function longint fdiv512(longint v);
    if (v >= 0) return v / 512;
    return -((-v + 511) / 512);
  endfunction

  // score the candidate and update mean/M2 for one accepted sample word
  function void note_sample(bit signed [15:0] s);
    peak_result_t r;
    int unsigned kk;
    int cand, ml, mr, dl, dr, score;
    longint xs, mnew, a, b, prod, d;
    bit [63:0] var_q18;
    bit [127:0] lhs, rhs;
    kk = (k_reg > 31) ? 31 : k_reg;
    ring[wr_idx] = s;
    wr_idx = (wr_idx + 1) % 64;
    n_samples++;
    if (fill < 65535) fill++;
    r = '{0, 0, 0, 0};
    if (fill >= 2 * kk + 2) begin
      cand = back_at(kk); ml = -1; mr = -1;
      for (int i = 0; i < kk; i++) begin
        dl = cand - back_at(2 * kk - i);
        dr = cand - back_at(kk - 1 - i);
        if (dl > ml) ml = dl;
        if (dr > mr) mr = dr;
      end
      score = ml + mr;
      r.evaluated = 1;
      r.peak_measure = 18'(score);
      if (n_scored != 32'hFFFF_FFFF) n_scored++;
      xs = longint'(score) * 262144;
      mnew = mean_q18 + (xs - mean_q18) / longint'(n_scored);
      a = fdiv512(xs - mnew);
      b = fdiv512(xs - mean_q18);
      prod = a * b;
      if (prod > 0) begin
        if (m2_q18 > 64'hFFFF_FFFF_FFFF_FFFF - prod) m2_q18 = '1;
        else m2_q18 += prod;
      end
      mean_q18 = mnew;
      var_q18 = m2_q18 / n_scored;
      d = xs - mnew;
      if (score > 0 && d > 0) begin
        lhs = 128'(d) * 128'(d);
        rhs = 128'(64'(h_reg) * h_reg * 4) * 128'(var_q18);
        if (lhs > rhs) begin
          r.peak_found = 1;
          peak_pos = n_samples;
        end
      end
    end
    r.peak_position = peak_pos;
    pending.push_back(r);
  endfunction

  function void check_result(bit ev, bit pf, bit signed [17:0] pm, bit [31:0] pp);
    peak_result_t e;
    if (pending.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (ev != e.evaluated) begin
      $error("evaluated: expected %0d, got %0d", e.evaluated, ev); errors++;
    end
    if (pf != e.peak_found) begin
      $error("peak_found: expected %0d, got %0d", e.peak_found, pf); errors++;
    end
    if (pm != e.peak_measure) begin
      $error("peak_measure: expected %0d, got %0d", e.peak_measure, pm); errors++;
    end
    if (pp != e.peak_position) begin
      $error("peak_position: expected %0d, got %0d", e.peak_position, pp); errors++;
    end
  endfunction
endclass

module tb;
  logic                                clk = 0;
  logic                                rst = 1;
  logic                                sample_valid = 0;
  logic                                sample_stall;
  logic signed [15:0]                  sample = '0;
  logic                                result_valid;
  logic                                result_stall = 0;
  logic                                evaluated;
  logic                                peak_found;
  logic signed [17:0]                  peak_measure;
  logic [s1pd_pkg::CNT_W-1:0]          peak_position;
  logic                                cfg_valid = 0;
  logic                                cfg_ready;
  logic [s1pd_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [s1pd_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  peak_scoreboard sb = new();
  int unsigned    idle_cycles;
  bit             timed_out;

  // long enough for k=31 with the threshold test, plus a long receiver stall
  localparam int unsigned STUCK_LIMIT = 4000;

  always #5 clk = ~clk;

  s1_peak_detector u_top (.*);

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver side: random stall, checks every accepted result word
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall)
        sb.check_result(evaluated, peak_found, peak_measure, peak_position);
      if (hold > 0) begin
        hold--;
        result_stall <= 1;
      end else begin
        hold = gap_len();
        result_stall <= (hold > 0);
      end
    end
  end

  // watchdog: no word moving on any channel for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STUCK_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays high into the next word when there is no gap
  task automatic send_sample(logic signed [15:0] s);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      sample_valid <= 0;
      repeat (g) @(posedge clk);
    end
    sample_valid <= 1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(s);
  endtask

  // block idle: all results back, then the tail of a possible in-flight word
  task automatic wait_drained();
    sample_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(logic [s1pd_pkg::CFG_IDX_W-1:0] idx,
                           logic [s1pd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // a noisy baseline with occasional spikes, so peaks actually occur
  function automatic logic signed [15:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom);
    if (r < 20) return 16'sd2000 + 16'($urandom_range(0, 25000));
    if (r < 23) return (r[0]) ? 16'sh7FFF : 16'sh8000;
    return 16'($signed($urandom_range(0, 400)) - 200);
  endfunction

  initial begin
    int unsigned ks[7];
    int unsigned hs[7];
    timed_out = 0;
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: warm-up at reset k, extremes and a clear spike
    send_sample(16'sh7FFF); send_sample(16'sh8000); send_sample(16'sh0000);
    send_sample(-16'sd1);   send_sample(16'sh5555); send_sample(16'shAAAA);
    send_sample(16'sd10);   send_sample(16'sd0);    send_sample(16'sh7FFF);
    send_sample(16'sd0);    send_sample(16'sh8000); send_sample(16'sd0);
    wait_drained();
    // zero neighbours: score -2 every word
    write_cfg(s1pd_pkg::REG_NEIGHBOR_COUNT, 12'd0);
    write_cfg(s1pd_pkg::REG_THRESHOLD_STDEVS, 12'd0);
    repeat (4) send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    wait_drained();
    // extra indexes are ignored; wide data bits above the field are masked
    write_cfg(2'd2, 12'hFFF);
    write_cfg(2'd3, 12'h0AB);
    write_cfg(s1pd_pkg::REG_NEIGHBOR_COUNT, 12'hFE1);
    repeat (5) send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    wait_drained();

    ks = '{1, 31, 2, 5, 3, 12, 1};
    hs = '{0, 4095, 256, 384, 100, 700, 4095};
    for (int p = 0; p < 7; p++) begin
      write_cfg(s1pd_pkg::REG_NEIGHBOR_COUNT, 12'(ks[p]));
      write_cfg(s1pd_pkg::REG_THRESHOLD_STDEVS, 12'(hs[p]));
      // big k is slow, so give it fewer words
      repeat ((ks[p] > 10) ? 150 : 320) send_sample(rand_sample());
      wait_drained();
    end

    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== s1_peak_detector.f =====
+incdir+sv
sv/s1pd_pkg.sv
sv/s1pd_ram.sv
sv/s1pd_div.sv
sv/s1_peak_detector.sv
dv/tb.sv
